### rtl/core/i2cmsd_pkg.sv
// Package with the target codes, register indexes and frame constants of the I2C slave decoder.
package i2cmsd_pkg;

   localparam int unsigned ADDR_W   = 7;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_CODEC_ADDR   = 2'd0;
   localparam csr_idx_type CSR_DISPLAY_ADDR = 2'd1;
   localparam csr_idx_type CSR_TOUCH_ADDR   = 2'd2;

   localparam addr_type CODEC_ADDR_RESET   = 7'h48;
   localparam addr_type DISPLAY_ADDR_RESET = 7'h38;
   localparam addr_type TOUCH_ADDR_RESET   = 7'h49;

   localparam logic [1:0] TGT_CODEC   = 2'd0;
   localparam logic [1:0] TGT_DISPLAY = 2'd1;
   localparam logic [1:0] TGT_TOUCH   = 2'd2;

   localparam logic FETCH_CODEC = 1'b0;
   localparam logic FETCH_TOUCH = 1'b1;

   localparam logic [7:0] FRAME_PEN_STATUS = 8'h83;
   localparam logic [7:0] FRAME_TRAILER    = 8'h0A;
   localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

   function automatic logic [7:0] display_frame_byte(input logic [7:0] idx,
                                                     input logic pen,
                                                     input logic [11:0] x,
                                                     input logic [11:0] y);
      logic [7:0] result;
      result = 8'h00;
      unique case (idx)
         8'd1: result = pen ? FRAME_PEN_STATUS : 8'h00;
         8'd2: result = pen ? x[11:4] : 8'h00;
         8'd3: result = pen ? y[11:4] : 8'h00;
         8'd4: result = pen ? {x[3:0], y[3:0]} : 8'h00;
         8'd6: result = FRAME_TRAILER;
         default: result = 8'h00;
      endcase
      return result;
   endfunction

endpackage

### rtl/core/i2c_multi_slave_bus_decoder.sv
// Top level of the three-address I2C slave that decodes sampled SCL and SDA line levels.
// The block accepts one line sample per clock cycle while the response is not stalled. A request
// is first held in the input register; the decode pass then fills the result register from it,
// unless a stalled response blocks it. A stalled response holds the result
// register, and the input register still takes one more request behind it.
module i2c_multi_slave_bus_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  i2cmsd_pkg::csr_idx_type  csr_index,
   input  i2cmsd_pkg::addr_type     csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_scl_level,
   input  logic                     req_sda_level,
   input  logic [7:0]               req_read_data,
   input  logic                     req_pen_down,
   input  logic [11:0]              req_touch_x,
   input  logic [11:0]              req_touch_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_sda_release,
   output logic                     rsp_write_valid,
   output logic [1:0]               rsp_write_target,
   output logic [6:0]               rsp_write_register,
   output logic [7:0]               rsp_write_byte,
   output logic                     rsp_fetch_valid,
   output logic                     rsp_fetch_target,
   output logic [6:0]               rsp_fetch_register,
   output logic                     rsp_address_error,
   output logic                     rsp_bus_active
);
   import i2cmsd_pkg::*;

   addr_type codec_addr_ff, display_addr_ff, touch_addr_ff;

   logic        in_valid_ff;
   logic        scl_ff, sda_ff, pen_ff;
   logic [7:0]  rdata_ff;
   logic [11:0] tx_ff, ty_ff;
   logic        advance;

   logic       last_scl_ff, last_sda_ff, in_transfer_ff, transmitting_ff, selected_ff;
   logic       read_mode_ff, nack_seen_ff, pointer_loaded_ff, increment_on_ff, sda_drive_ff;
   logic [3:0] bit_count_ff;
   logic [7:0] shift_reg_ff, byte_count_ff, tx_shift_ff;
   addr_type   slave_addr_ff, reg_pointer_ff;

   logic       last_scl_in, last_sda_in, in_transfer_in, transmitting_in, selected_in;
   logic       read_mode_in, nack_seen_in, pointer_loaded_in, increment_on_in, sda_drive_in;
   logic [3:0] bit_count_in;
   logic [7:0] shift_reg_in, byte_count_in, tx_shift_in;
   addr_type   slave_addr_in, reg_pointer_in;

   logic       w_valid, f_valid, f_tgt, a_err;
   logic [1:0] w_tgt;
   logic [6:0] w_reg, f_reg;
   logic [7:0] w_byte;

   logic       rsp_valid_ff;
   logic       sda_release_ff, write_valid_ff, fetch_valid_ff, fetch_target_ff;
   logic       address_error_ff, bus_active_ff;
   logic [1:0] write_target_ff;
   logic [6:0] write_register_ff, fetch_register_ff;
   logic [7:0] write_byte_ff;

   logic [7:0] shifted;
   logic [1:0] cur_target;
   addr_type   new_addr;
   logic       new_known, ack, nack_next, tx_next;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_addr_ff   <= CODEC_ADDR_RESET;
         display_addr_ff <= DISPLAY_ADDR_RESET;
         touch_addr_ff   <= TOUCH_ADDR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CODEC_ADDR:   codec_addr_ff   <= csr_data;
            CSR_DISPLAY_ADDR: display_addr_ff <= csr_data;
            CSR_TOUCH_ADDR:   touch_addr_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         scl_ff   <= req_scl_level;
         sda_ff   <= req_sda_level;
         rdata_ff <= req_read_data;
         pen_ff   <= req_pen_down;
         tx_ff    <= req_touch_x;
         ty_ff    <= req_touch_y;
      end
   end

   assign shifted   = {shift_reg_ff[6:0], sda_ff};
   assign new_addr  = shifted[7:1];
   assign new_known = (new_addr == codec_addr_ff) || (new_addr == display_addr_ff) ||
                      (new_addr == touch_addr_ff);
   assign ack       = !transmitting_ff && selected_ff &&
                      ((byte_count_ff == 8'd0) || !read_mode_ff);
   assign nack_next = transmitting_ff ? sda_ff : nack_seen_ff;
   assign tx_next   = selected_ff && read_mode_ff && !nack_next;

   always_comb begin
      priority if (slave_addr_ff == display_addr_ff) begin
         cur_target = TGT_DISPLAY;
      end else if (slave_addr_ff == touch_addr_ff) begin
         cur_target = TGT_TOUCH;
      end else begin
         cur_target = TGT_CODEC;
      end
   end

   always_comb begin
      last_scl_in       = scl_ff;
      last_sda_in       = sda_ff;
      in_transfer_in    = in_transfer_ff;
      transmitting_in   = transmitting_ff;
      selected_in       = selected_ff;
      read_mode_in      = read_mode_ff;
      nack_seen_in      = nack_seen_ff;
      pointer_loaded_in = pointer_loaded_ff;
      increment_on_in   = increment_on_ff;
      sda_drive_in      = sda_drive_ff;
      bit_count_in      = bit_count_ff;
      shift_reg_in      = shift_reg_ff;
      byte_count_in     = byte_count_ff;
      tx_shift_in       = tx_shift_ff;
      slave_addr_in     = slave_addr_ff;
      reg_pointer_in    = reg_pointer_ff;
      w_valid = 1'b0;
      w_tgt   = TGT_CODEC;
      w_reg   = 7'd0;
      w_byte  = 8'd0;
      f_valid = 1'b0;
      f_tgt   = FETCH_CODEC;
      f_reg   = 7'd0;
      a_err   = 1'b0;

      if (scl_ff && last_scl_ff) begin
         if (last_sda_ff && !sda_ff) begin
            in_transfer_in  = 1'b1;
            bit_count_in    = 4'd0;
            shift_reg_in    = 8'd0;
            transmitting_in = 1'b0;
            byte_count_in   = 8'd0;
            selected_in     = 1'b0;
            nack_seen_in    = 1'b0;
            sda_drive_in    = 1'b1;
         end else if (!last_sda_ff && sda_ff) begin
            in_transfer_in = 1'b0;
            sda_drive_in   = 1'b1;
         end
      end else if (in_transfer_ff) begin
         if (last_scl_ff && !scl_ff) begin
            if (bit_count_ff < BITS_PER_BYTE) begin
               sda_drive_in = (transmitting_ff && selected_ff) ?
                              tx_shift_ff[~bit_count_ff[2:0]] : 1'b1;
            end else begin
               sda_drive_in = !ack;
            end
         end else if (!last_scl_ff && scl_ff) begin
            if (bit_count_ff < BITS_PER_BYTE) begin
               bit_count_in = bit_count_ff + 4'd1;
               if (!transmitting_ff) begin
                  shift_reg_in = shifted;
               end
               if ((bit_count_ff == BITS_PER_BYTE - 4'd1) && !transmitting_ff) begin
                  if (byte_count_ff == 8'd0) begin
                     slave_addr_in     = new_addr;
                     read_mode_in      = shifted[0];
                     selected_in       = new_known;
                     pointer_loaded_in = 1'b0;
                     a_err             = !new_known;
                  end else if (selected_ff && !read_mode_ff) begin
                     if ((cur_target == TGT_CODEC) && !pointer_loaded_ff) begin
                        reg_pointer_in    = shifted[6:0];
                        increment_on_in   = shifted[7];
                        pointer_loaded_in = 1'b1;
                     end else begin
                        w_valid = 1'b1;
                        w_tgt   = cur_target;
                        w_byte  = shifted;
                        if (cur_target == TGT_CODEC) begin
                           w_reg = reg_pointer_ff;
                           if (increment_on_ff) begin
                              reg_pointer_in = reg_pointer_ff + 7'd1;
                           end
                        end
                     end
                  end
               end
            end else begin
               nack_seen_in    = nack_next;
               bit_count_in    = 4'd0;
               shift_reg_in    = 8'd0;
               byte_count_in   = byte_count_ff + 8'd1;
               transmitting_in = tx_next;
               if (tx_next) begin
                  unique case (cur_target)
                     TGT_DISPLAY: begin
                        tx_shift_in = display_frame_byte(byte_count_in, pen_ff, tx_ff, ty_ff);
                     end
                     TGT_TOUCH: begin
                        tx_shift_in = rdata_ff;
                        f_valid     = 1'b1;
                        f_tgt       = FETCH_TOUCH;
                     end
                     default: begin
                        tx_shift_in = rdata_ff;
                        f_valid     = 1'b1;
                        f_tgt       = FETCH_CODEC;
                        f_reg       = reg_pointer_ff;
                        if (increment_on_ff) begin
                           reg_pointer_in = reg_pointer_ff + 7'd1;
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scl_ff       <= 1'b1;
         last_sda_ff       <= 1'b1;
         in_transfer_ff    <= 1'b0;
         transmitting_ff   <= 1'b0;
         selected_ff       <= 1'b0;
         read_mode_ff      <= 1'b0;
         nack_seen_ff      <= 1'b0;
         pointer_loaded_ff <= 1'b0;
         increment_on_ff   <= 1'b0;
         sda_drive_ff      <= 1'b1;
         bit_count_ff      <= 4'd0;
         shift_reg_ff      <= 8'd0;
         byte_count_ff     <= 8'd0;
         tx_shift_ff       <= 8'd0;
         slave_addr_ff     <= 7'd0;
         reg_pointer_ff    <= 7'd0;
      end else if (advance) begin
         last_scl_ff       <= last_scl_in;
         last_sda_ff       <= last_sda_in;
         in_transfer_ff    <= in_transfer_in;
         transmitting_ff   <= transmitting_in;
         selected_ff       <= selected_in;
         read_mode_ff      <= read_mode_in;
         nack_seen_ff      <= nack_seen_in;
         pointer_loaded_ff <= pointer_loaded_in;
         increment_on_ff   <= increment_on_in;
         sda_drive_ff      <= sda_drive_in;
         bit_count_ff      <= bit_count_in;
         shift_reg_ff      <= shift_reg_in;
         byte_count_ff     <= byte_count_in;
         tx_shift_ff       <= tx_shift_in;
         slave_addr_ff     <= slave_addr_in;
         reg_pointer_ff    <= reg_pointer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sda_release_ff    <= sda_drive_in;
         write_valid_ff    <= w_valid;
         write_target_ff   <= w_tgt;
         write_register_ff <= w_reg;
         write_byte_ff     <= w_byte;
         fetch_valid_ff    <= f_valid;
         fetch_target_ff   <= f_tgt;
         fetch_register_ff <= f_reg;
         address_error_ff  <= a_err;
         bus_active_ff     <= in_transfer_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sda_release    = sda_release_ff;
   assign rsp_write_valid    = write_valid_ff;
   assign rsp_write_target   = write_target_ff;
   assign rsp_write_register = write_register_ff;
   assign rsp_write_byte     = write_byte_ff;
   assign rsp_fetch_valid    = fetch_valid_ff;
   assign rsp_fetch_target   = fetch_target_ff;
   assign rsp_fetch_register = fetch_register_ff;
   assign rsp_address_error  = address_error_ff;
   assign rsp_bus_active     = bus_active_ff;

endmodule

### rtl/core/i2cmsd_checker.sv
// Port-level checker for the I2C slave decoder and the bind that attaches it.
module i2cmsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_write_valid,
   input logic [1:0] rsp_write_target,
   input logic [7:0] rsp_write_byte,
   input logic       rsp_fetch_valid,
   input logic       rsp_address_error
);
   import i2cmsd_pkg::*;

   // A stalled response stays valid and keeps its write byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_byte))
      else $error("stalled response changed");

   // A data write and a read fetch fall on different clock edges of the bus.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_write_valid && rsp_fetch_valid))
      else $error("write and fetch in one response");

   // An address error produces neither a write nor a fetch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_error |-> !rsp_write_valid && !rsp_fetch_valid)
      else $error("address error with data activity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_write_target == TGT_CODEC ||
         rsp_write_target == TGT_DISPLAY || rsp_write_target == TGT_TOUCH)
      else $error("write target out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_write_byte == 8'd0 &&
         rsp_write_target == TGT_CODEC)
      else $error("write fields set without a write");

endmodule

bind i2c_multi_slave_bus_decoder i2cmsd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_valid   (rsp_write_valid),
   .rsp_write_target  (rsp_write_target),
   .rsp_write_byte    (rsp_write_byte),
   .rsp_fetch_valid   (rsp_fetch_valid),
   .rsp_address_error (rsp_address_error)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-address I2C slave decoder, driven by bit-level bus traffic.
module tb_top;
   import i2cmsd_pkg::*;

   typedef struct packed {
      logic        scl;
      logic        sda;
      logic [7:0]  read_data;
      logic        pen;
      logic [11:0] touch_x;
      logic [11:0] touch_y;
   } line_sample_type;

   typedef struct packed {
      logic       sda_release;
      logic       write_valid;
      logic [1:0] write_target;
      logic [6:0] write_register;
      logic [7:0] write_byte;
      logic       fetch_valid;
      logic       fetch_target;
      logic [6:0] fetch_register;
      logic       address_error;
      logic       bus_active;
   } line_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_CODEC_ADDR;
   addr_type    csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_scl_level = 1'b1;
   logic        req_sda_level = 1'b1;
   logic [7:0]  req_read_data = '0;
   logic        req_pen_down = 1'b0;
   logic [11:0] req_touch_x = '0;
   logic [11:0] req_touch_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_sda_release;
   logic        rsp_write_valid;
   logic [1:0]  rsp_write_target;
   logic [6:0]  rsp_write_register;
   logic [7:0]  rsp_write_byte;
   logic        rsp_fetch_valid;
   logic        rsp_fetch_target;
   logic [6:0]  rsp_fetch_register;
   logic        rsp_address_error;
   logic        rsp_bus_active;

   // Slave addresses as the block currently holds them.
   addr_type cfg_codec = CODEC_ADDR_RESET;
   addr_type cfg_display = DISPLAY_ADDR_RESET;
   addr_type cfg_touch = TOUCH_ADDR_RESET;

   // Bus decoder state mirrored from the accepted line samples.
   logic       prev_scl = 1'b1;
   logic       prev_sda = 1'b1;
   logic       bus_busy = 1'b0;
   logic       sending = 1'b0;
   logic       addressed = 1'b0;
   logic       is_read = 1'b0;
   logic       master_nacked = 1'b0;
   logic       map_loaded = 1'b0;
   logic       auto_inc = 1'b0;
   logic [3:0] bit_idx = '0;
   logic [7:0] rx_byte = '0;
   logic [7:0] byte_idx = '0;
   addr_type   dev_addr = '0;
   logic [6:0] reg_ptr = '0;
   logic [7:0] tx_byte = '0;
   logic       drive_level = 1'b1;

   line_result_type line_results_q[$];
   bit no_idle = 1'b0;
   int rsp_hold = 0;
   int failures = 0;
   int samples_sent = 0;
   int writes_seen = 0;
   int fetches_seen = 0;
   int addr_errors_seen = 0;
   int address_settings = 0;

   i2c_multi_slave_bus_decoder u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_scl_level      (req_scl_level),
      .req_sda_level      (req_sda_level),
      .req_read_data      (req_read_data),
      .req_pen_down       (req_pen_down),
      .req_touch_x        (req_touch_x),
      .req_touch_y        (req_touch_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sda_release    (rsp_sda_release),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_target   (rsp_write_target),
      .rsp_write_register (rsp_write_register),
      .rsp_write_byte     (rsp_write_byte),
      .rsp_fetch_valid    (rsp_fetch_valid),
      .rsp_fetch_target   (rsp_fetch_target),
      .rsp_fetch_register (rsp_fetch_register),
      .rsp_address_error  (rsp_address_error),
      .rsp_bus_active     (rsp_bus_active)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [11:0] skewed_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] slave_of(input addr_type a);
      if (a == cfg_display) return TGT_DISPLAY;
      if (a == cfg_touch) return TGT_TOUCH;
      return TGT_CODEC;
   endfunction

   function automatic line_result_type decode_sample(input line_sample_type s);
      line_result_type r;
      logic [1:0]      tgt;
      r = '0;
      if (s.scl && prev_scl) begin
         if (prev_sda && !s.sda) begin
            bus_busy = 1'b1;
            bit_idx = '0;
            rx_byte = '0;
            sending = 1'b0;
            byte_idx = '0;
            addressed = 1'b0;
            master_nacked = 1'b0;
            drive_level = 1'b1;
         end else if (!prev_sda && s.sda) begin
            bus_busy = 1'b0;
            drive_level = 1'b1;
         end
      end else if (bus_busy) begin
         if (prev_scl && !s.scl) begin
            if (bit_idx < BITS_PER_BYTE) begin
               drive_level = (sending && addressed) ? tx_byte[7 - bit_idx] : 1'b1;
            end else begin
               drive_level = !(!sending && addressed && (byte_idx == 0 || !is_read));
            end
         end else if (!prev_scl && s.scl) begin
            if (bit_idx < BITS_PER_BYTE) begin
               if (!sending) rx_byte = {rx_byte[6:0], s.sda};
               bit_idx = bit_idx + 1'b1;
               if (bit_idx == BITS_PER_BYTE && !sending) begin
                  if (byte_idx == 0) begin
                     dev_addr = rx_byte[7:1];
                     is_read = rx_byte[0];
                     addressed = (dev_addr == cfg_codec) || (dev_addr == cfg_display) ||
                                 (dev_addr == cfg_touch);
                     map_loaded = 1'b0;
                     r.address_error = !addressed;
                  end else if (addressed && !is_read) begin
                     tgt = slave_of(dev_addr);
                     if (tgt == TGT_CODEC && !map_loaded) begin
                        reg_ptr = rx_byte[6:0];
                        auto_inc = rx_byte[7];
                        map_loaded = 1'b1;
                     end else begin
                        r.write_valid = 1'b1;
                        r.write_target = tgt;
                        r.write_byte = rx_byte;
                        if (tgt == TGT_CODEC) begin
                           r.write_register = reg_ptr;
                           if (auto_inc) reg_ptr = reg_ptr + 1'b1;
                        end
                     end
                  end
               end
            end else begin
               if (sending) master_nacked = s.sda;
               bit_idx = '0;
               rx_byte = '0;
               byte_idx = byte_idx + 1'b1;
               sending = addressed && is_read && !master_nacked;
               if (sending) begin
                  tgt = slave_of(dev_addr);
                  if (tgt == TGT_DISPLAY) begin
                     case (byte_idx)
                        8'd1: tx_byte = s.pen ? FRAME_PEN_STATUS : 8'h00;
                        8'd2: tx_byte = s.pen ? s.touch_x[11:4] : 8'h00;
                        8'd3: tx_byte = s.pen ? s.touch_y[11:4] : 8'h00;
                        8'd4: tx_byte = s.pen ? {s.touch_x[3:0], s.touch_y[3:0]} : 8'h00;
                        8'd6: tx_byte = FRAME_TRAILER;
                        default: tx_byte = 8'h00;
                     endcase
                  end else begin
                     tx_byte = s.read_data;
                     r.fetch_valid = 1'b1;
                     if (tgt == TGT_TOUCH) begin
                        r.fetch_target = FETCH_TOUCH;
                     end else begin
                        r.fetch_target = FETCH_CODEC;
                        r.fetch_register = reg_ptr;
                        if (auto_inc) reg_ptr = reg_ptr + 1'b1;
                     end
                  end
               end
            end
         end
      end
      prev_scl = s.scl;
      prev_sda = s.sda;
      r.sda_release = drive_level;
      r.bus_active = bus_busy;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      line_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (line_results_q.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               failures++;
            end else begin
               want = line_results_q.pop_front();
               check_field("sda_release", 8'(want.sda_release), 8'(rsp_sda_release));
               check_field("write_valid", 8'(want.write_valid), 8'(rsp_write_valid));
               check_field("write_target", 8'(want.write_target), 8'(rsp_write_target));
               check_field("write_register", 8'(want.write_register),
                           8'(rsp_write_register));
               check_field("write_byte", want.write_byte, rsp_write_byte);
               check_field("fetch_valid", 8'(want.fetch_valid), 8'(rsp_fetch_valid));
               check_field("fetch_target", 8'(want.fetch_target), 8'(rsp_fetch_target));
               check_field("fetch_register", 8'(want.fetch_register),
                           8'(rsp_fetch_register));
               check_field("address_error", 8'(want.address_error), 8'(rsp_address_error));
               check_field("bus_active", 8'(want.bus_active), 8'(rsp_bus_active));
            end
            rsp_hold = idle_draw();
            rsp_ready <= (rsp_hold == 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= (rsp_hold == 0);
         end
      end
   end

   // Sends one line sample; a wired sample resolves SDA against the slave's own drive.
   task automatic drive_line(input logic scl, input logic sda, input logic wired);
      line_sample_type s;
      line_result_type r;
      int              gap;
      s.scl = scl;
      s.sda = wired ? (sda & drive_level) : sda;
      s.read_data = 8'(skewed_word());
      s.pen = 1'($urandom);
      s.touch_x = skewed_word();
      s.touch_y = skewed_word();
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_scl_level <= s.scl;
      req_sda_level <= s.sda;
      req_read_data <= s.read_data;
      req_pen_down <= s.pen;
      req_touch_x <= s.touch_x;
      req_touch_y <= s.touch_y;
      do @(posedge clock); while (!req_ready);
      r = decode_sample(s);
      line_results_q.push_back(r);
      samples_sent++;
      writes_seen += r.write_valid;
      fetches_seen += r.fetch_valid;
      addr_errors_seen += r.address_error;
   endtask

   task automatic settle_bus();
      req_valid <= 1'b0;
      while (line_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_addresses(input addr_type codec, input addr_type display,
                                input addr_type touch);
      csr_idx_type idxs[3];
      addr_type    values[3];
      idxs = '{CSR_CODEC_ADDR, CSR_DISPLAY_ADDR, CSR_TOUCH_ADDR};
      values = '{codec, display, touch};
      settle_bus();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idxs[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_codec = codec;
      cfg_display = display;
      cfg_touch = touch;
      address_settings++;
   endtask

   task automatic bus_bit(input logic b);
      drive_line(1'b0, b, 1'b1);
      if ($urandom_range(0, 7) == 0) drive_line(1'b0, b, 1'b1);
      drive_line(1'b1, b, 1'b1);
      if ($urandom_range(0, 7) == 0) drive_line(1'b1, b, 1'b1);
   endtask

   task automatic bus_byte(input logic [7:0] data, input logic ninth);
      for (int i = 7; i >= 0; i--) bus_bit(data[i]);
      bus_bit(ninth);
   endtask

   task automatic bus_start();
      if (bus_busy || !prev_scl) drive_line(1'b0, 1'b1, 1'b1);
      drive_line(1'b1, 1'b1, 1'b1);
      drive_line(1'b1, 1'b0, 1'b1);
   endtask

   task automatic bus_stop();
      drive_line(1'b0, 1'b0, 1'b1);
      drive_line(1'b1, 1'b0, 1'b1);
      drive_line(1'b1, 1'b1, 1'b1);
   endtask

   // The master releases SDA in each write ack slot; on reads it acknowledges bytes before nack_at.
   task automatic bus_transfer(input addr_type dev, input logic rd, input int nbytes,
                               input int nack_at, input bit stop);
      bus_start();
      bus_byte({dev, rd}, 1'b1);
      for (int i = 0; i < nbytes; i++) begin
         if (rd) bus_byte(8'hFF, i >= nack_at);
         else bus_byte(8'(skewed_word()), 1'b1);
      end
      if (stop) bus_stop();
   endtask

   task automatic test_line_extremes();
      drive_line(1'b1, 1'b1, 1'b0);
      drive_line(1'b0, 1'b1, 1'b0);
      drive_line(1'b0, 1'b0, 1'b0);
      drive_line(1'b1, 1'b0, 1'b0);
      drive_line(1'b1, 1'b1, 1'b0);
      drive_line(1'b1, 1'b0, 1'b0);
      drive_line(1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_codec_access();
      bus_start();
      bus_byte({cfg_codec, 1'b0}, 1'b1);
      bus_byte(8'hFE, 1'b1);
      bus_byte(8'h00, 1'b1);
      bus_byte(8'hFF, 1'b1);
      bus_byte(8'hA5, 1'b1);
      bus_start();
      bus_byte({cfg_codec, 1'b1}, 1'b1);
      bus_byte(8'hFF, 1'b0);
      bus_byte(8'hFF, 1'b1);
      bus_stop();
      bus_start();
      bus_byte({cfg_codec, 1'b0}, 1'b1);
      bus_byte(8'h05, 1'b1);
      bus_byte(8'h3C, 1'b1);
      bus_byte(8'hC3, 1'b1);
      bus_stop();
   endtask

   task automatic test_display_frame();
      bus_transfer(cfg_display, 1'b0, 1, 0, 1'b1);
      bus_transfer(cfg_display, 1'b1, 8, 7, 1'b1);
   endtask

   task automatic test_touch_commands();
      bus_transfer(cfg_touch, 1'b0, 2, 0, 1'b1);
      bus_transfer(cfg_touch, 1'b1, 3, 1, 1'b1);
   endtask

   task automatic test_unknown_address();
      bus_transfer(7'h10, 1'b0, 2, 0, 1'b1);
      bus_transfer(7'h7F, 1'b1, 1, 0, 1'b1);
   endtask

   task automatic test_address_overlap();
      set_addresses(7'h7F, 7'h7F, 7'h7F);
      bus_transfer(7'h7F, 1'b0, 1, 0, 1'b1);
      bus_transfer(7'h7F, 1'b1, 2, 1, 1'b1);
      set_addresses(7'h00, 7'h7F, 7'h00);
      bus_transfer(7'h00, 1'b0, 2, 0, 1'b1);
      set_addresses(7'h00, 7'h01, 7'h7F);
      bus_transfer(7'h00, 1'b0, 2, 0, 1'b0);
      bus_transfer(7'h00, 1'b1, 2, 1, 1'b1);
      // Retarget the display address while it is selected; it is then served as the codec.
      set_addresses(CODEC_ADDR_RESET, DISPLAY_ADDR_RESET, TOUCH_ADDR_RESET);
      bus_start();
      bus_byte({cfg_display, 1'b0}, 1'b1);
      bus_byte(8'h11, 1'b1);
      set_addresses(CODEC_ADDR_RESET, 7'h11, TOUCH_ADDR_RESET);
      bus_byte(8'h82, 1'b1);
      bus_byte(8'h5A, 1'b1);
      bus_stop();
      set_addresses(CODEC_ADDR_RESET, DISPLAY_ADDR_RESET, TOUCH_ADDR_RESET);
   endtask

   task automatic test_random_traffic();
      int       first;
      int       choice;
      int       nbytes;
      addr_type dev;
      addr_type same;
      logic     rd;
      first = samples_sent;
      while (samples_sent - first < 400) begin
         no_idle = ($urandom_range(0, 3) == 0);
         choice = $urandom_range(0, 19);
         case ($urandom_range(0, 5))
            0: dev = cfg_codec;
            1: dev = cfg_display;
            2: dev = cfg_touch;
            3: dev = 7'($urandom);
            default: dev = cfg_codec;
         endcase
         rd = 1'($urandom);
         nbytes = (dev == cfg_display && rd && $urandom_range(0, 2) == 0) ? 8 :
                  $urandom_range(0, 4);
         if (choice == 0) begin
            same = 7'($urandom);
            case ($urandom_range(0, 3))
               0: set_addresses(CODEC_ADDR_RESET, DISPLAY_ADDR_RESET, TOUCH_ADDR_RESET);
               1: set_addresses(same, same, same);
               2: set_addresses(7'($urandom), 7'($urandom), 7'($urandom));
               default: set_addresses(7'h00, 7'h7F, same);
            endcase
         end else if (choice == 1) begin
            repeat ($urandom_range(1, 6)) drive_line(1'($urandom), 1'($urandom), 1'b0);
         end else if (choice == 2) begin
            bus_start();
            repeat ($urandom_range(1, 7)) bus_bit(1'($urandom));
            bus_stop();
         end else if (choice <= 6) begin
            bus_transfer(cfg_codec, 1'b0, 1, 0, 1'b0);
            nbytes = $urandom_range(1, 4);
            bus_transfer(cfg_codec, 1'b1, nbytes, $urandom_range(0, nbytes - 1), 1'b1);
         end else begin
            bus_transfer(dev, rd, nbytes, (nbytes > 0) ? $urandom_range(0, nbytes - 1) : 0,
                         $urandom_range(0, 3) != 0);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_line_extremes();
      test_codec_access();
      test_display_frame();
      test_touch_commands();
      test_unknown_address();
      test_address_overlap();
      test_random_traffic();
      settle_bus();
      $display("Sent %0d line samples covering start, stop, address, write and read phases.",
               samples_sent);
      $display("Checked %0d slave writes, %0d read fetches, %0d address errors, %0d settings.",
               writes_seen, fetches_seen, addr_errors_seen, address_settings);
      if (failures == 0 && line_results_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
